// ===== sv/aetm_pkg.sv =====
package aetm_pkg;

  localparam int ADC_BITS  = 12;
  localparam int FRAC_BITS = 8;
  localparam int AVG_BITS  = ADC_BITS + FRAC_BITS;
  localparam int ALPHA_BITS = 8;
  localparam int ADDR_BITS = 4;

  // Unity weight in Q8.
  localparam logic [ALPHA_BITS:0] ALPHA_ONE = 9'd256;

  localparam logic [ADC_BITS-1:0]   RAW_MIN_RESET   = 12'd100;
  localparam logic [ADC_BITS-1:0]   RAW_MAX_RESET   = 12'd4000;
  localparam logic [ALPHA_BITS-1:0] ALPHA_RESET     = 8'd230;
  localparam logic [ADC_BITS-1:0]   THRESHOLD_RESET = 12'd10;

  localparam logic [1:0] REG_RAW_MIN   = 2'd0;
  localparam logic [1:0] REG_RAW_MAX   = 2'd1;
  localparam logic [1:0] REG_ALPHA     = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  typedef struct packed {
    logic                has_sample;
    logic [ADC_BITS-1:0] sample;
    logic                take_up;
    logic                take_down;
  } in_item_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] last_sample;
    logic [AVG_BITS-1:0] filtered;
    logic                primed;
    logic                fault;
    logic                rising;
    logic                falling;
  } out_item_t;

endpackage

// ===== sv/adc_ema_trend_monitor_top.sv =====
// A result appears in the output register in the cycle after its item is accepted.
// Throughput: one item per cycle; the filter state feeds back through a single
// combinational update (two narrow multiplies and an add) into its own registers.
// The input stalls only while a finished result waits to be taken.
// Reset (rst, synchronous, active high) clears the filter state, the flags and the
// output valid, and returns the configuration registers to their defaults.
module adc_ema_trend_monitor_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  aetm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output aetm_pkg::out_item_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [aetm_pkg::ADDR_BITS-1:0] paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import aetm_pkg::*;

  localparam int PROD_BITS = AVG_BITS + ALPHA_BITS + 2;

  logic [ADC_BITS-1:0]   raw_min;
  logic [ADC_BITS-1:0]   raw_max;
  logic [ALPHA_BITS-1:0] alpha_q8;
  logic [ADC_BITS-1:0]   delta_threshold;

  logic [ADC_BITS-1:0] raw_hold, raw_hold_next;
  logic [AVG_BITS-1:0] avg_value, avg_value_next;
  logic                avg_primed, avg_primed_next;
  logic                fault_flag, fault_flag_next;
  logic                rise_flag, rise_flag_next;
  logic                fall_flag, fall_flag_next;

  logic                accept;
  logic                bad;
  logic [1:0]          reg_index;
  logic [ALPHA_BITS:0] new_weight;
  logic [AVG_BITS-1:0] sample_fx;
  logic [PROD_BITS-1:0] blend;
  logic [AVG_BITS-1:0] avg_update;
  logic signed [ADC_BITS+1:0] diff;
  logic signed [ADC_BITS+1:0] thr;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_BITS-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_min         <= RAW_MIN_RESET;
      raw_max         <= RAW_MAX_RESET;
      alpha_q8        <= ALPHA_RESET;
      delta_threshold <= THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_index)
        REG_RAW_MIN:   raw_min         <= pwdata[ADC_BITS-1:0];
        REG_RAW_MAX:   raw_max         <= pwdata[ADC_BITS-1:0];
        REG_ALPHA:     alpha_q8        <= pwdata[ALPHA_BITS-1:0];
        REG_THRESHOLD: delta_threshold <= pwdata[ADC_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      REG_RAW_MIN:   prdata = {{(32-ADC_BITS){1'b0}}, raw_min};
      REG_RAW_MAX:   prdata = {{(32-ADC_BITS){1'b0}}, raw_max};
      REG_ALPHA:     prdata = {{(32-ALPHA_BITS){1'b0}}, alpha_q8};
      REG_THRESHOLD: prdata = {{(32-ADC_BITS){1'b0}}, delta_threshold};
      default:       prdata = 32'd0;
    endcase
  end

  // The output register holds one result; a new item enters whenever it is
  // empty or its result leaves in the same cycle.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  assign bad        = (in_data.sample < raw_min) || (in_data.sample > raw_max);
  assign new_weight = ALPHA_ONE - {1'b0, alpha_q8};
  assign sample_fx  = {in_data.sample, {FRAC_BITS{1'b0}}};
  assign blend      = PROD_BITS'(alpha_q8) * PROD_BITS'(avg_value)
                    + PROD_BITS'(new_weight) * PROD_BITS'(sample_fx);
  assign avg_update = blend[ALPHA_BITS +: AVG_BITS];
  assign diff = $signed({2'b00, avg_update[AVG_BITS-1:FRAC_BITS]})
              - $signed({2'b00, avg_value[AVG_BITS-1:FRAC_BITS]});
  assign thr  = $signed({2'b00, delta_threshold});

  // State after the sample is handled; this is what the result reports.
  always_comb begin
    raw_hold_next   = raw_hold;
    avg_value_next  = avg_value;
    avg_primed_next = avg_primed;
    fault_flag_next = fault_flag;
    rise_flag_next  = rise_flag;
    fall_flag_next  = fall_flag;
    if (in_data.has_sample) begin
      raw_hold_next   = in_data.sample;
      fault_flag_next = bad;
      if (bad != fault_flag) begin
        rise_flag_next = 1'b0;
        fall_flag_next = 1'b0;
      end
      if (!bad) begin
        avg_primed_next = 1'b1;
        if (!avg_primed) begin
          avg_value_next = sample_fx;
        end else begin
          avg_value_next = avg_update;
          if (diff > thr) begin
            fall_flag_next = 1'b1;
          end else if (diff < -thr) begin
            rise_flag_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_hold   <= '0;
      avg_value  <= '0;
      avg_primed <= 1'b0;
      fault_flag <= 1'b0;
      rise_flag  <= 1'b0;
      fall_flag  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (accept) begin
        raw_hold   <= raw_hold_next;
        avg_value  <= avg_value_next;
        avg_primed <= avg_primed_next;
        fault_flag <= fault_flag_next;
        // Take bits clear the flags only after they have been reported.
        rise_flag  <= rise_flag_next && !in_data.take_up;
        fall_flag  <= fall_flag_next && !in_data.take_down;
        out_valid  <= 1'b1;
      end else if (!out_stall) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // Before priming the average register is still zero, so it reads as zero.
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.last_sample <= raw_hold_next;
      out_data.filtered    <= avg_value_next;
      out_data.primed      <= avg_primed_next;
      out_data.fault       <= fault_flag_next;
      out_data.rising      <= rise_flag_next;
      out_data.falling     <= fall_flag_next;
    end
  end

endmodule

// ===== dv/adc_ema_trend_monitor_top_test.sv =====
// Tracks the filter, the window check and the sticky trend flags, and holds the
// reports that the block owes for the items it has taken so far.
class ema_trend_scoreboard;
  logic [aetm_pkg::ADC_BITS-1:0]   win_lo;
  logic [aetm_pkg::ADC_BITS-1:0]   win_hi;
  logic [aetm_pkg::ALPHA_BITS-1:0] old_weight;
  logic [aetm_pkg::ADC_BITS-1:0]   trend_step;

  logic [aetm_pkg::ADC_BITS-1:0] last_raw;
  logic [aetm_pkg::AVG_BITS-1:0] avg_fix;
  logic have_avg;
  logic out_of_window;
  logic temp_rise;
  logic temp_fall;

  aetm_pkg::out_item_t owed_reports[$];
  int bad_reports;

  function new();
    win_lo        = aetm_pkg::RAW_MIN_RESET;
    win_hi        = aetm_pkg::RAW_MAX_RESET;
    old_weight    = aetm_pkg::ALPHA_RESET;
    trend_step    = aetm_pkg::THRESHOLD_RESET;
    last_raw      = '0;
    avg_fix       = '0;
    have_avg      = 1'b0;
    out_of_window = 1'b0;
    temp_rise     = 1'b0;
    temp_fall     = 1'b0;
    bad_reports   = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] value);
    case (idx)
      aetm_pkg::REG_RAW_MIN:   win_lo = value[aetm_pkg::ADC_BITS-1:0];
      aetm_pkg::REG_RAW_MAX:   win_hi = value[aetm_pkg::ADC_BITS-1:0];
      aetm_pkg::REG_ALPHA:     old_weight = value[aetm_pkg::ALPHA_BITS-1:0];
      aetm_pkg::REG_THRESHOLD: trend_step = value[aetm_pkg::ADC_BITS-1:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return owed_reports.size();
  endfunction

  // Called for every accepted input transfer.
  function void absorb_item(aetm_pkg::in_item_t it);
    aetm_pkg::out_item_t rep;
    logic bad;
    logic [aetm_pkg::AVG_BITS-1:0] prev;
    logic [39:0] mix;
    int change;
    if (it.has_sample) begin
      bad = (it.sample < win_lo) || (it.sample > win_hi);
      last_raw = it.sample;
      if (bad != out_of_window) begin
        temp_rise = 1'b0;
        temp_fall = 1'b0;
      end
      out_of_window = bad;
      if (!bad) begin
        if (!have_avg) begin
          avg_fix  = aetm_pkg::AVG_BITS'(40'(it.sample) << aetm_pkg::FRAC_BITS);
          have_avg = 1'b1;
        end else begin
          prev = avg_fix;
          mix = 40'(old_weight) * 40'(prev)
              + (40'(aetm_pkg::ALPHA_ONE) - 40'(old_weight))
                * (40'(it.sample) << aetm_pkg::FRAC_BITS);
          avg_fix = aetm_pkg::AVG_BITS'(mix >> aetm_pkg::ALPHA_BITS);
          change = int'(avg_fix >> aetm_pkg::FRAC_BITS)
                 - int'(prev >> aetm_pkg::FRAC_BITS);
          // An ADC that climbs means the temperature is dropping.
          if (change > int'(trend_step))
            temp_fall = 1'b1;
          else if (change < -int'(trend_step))
            temp_rise = 1'b1;
        end
      end
    end
    rep.last_sample = last_raw;
    rep.filtered    = have_avg ? avg_fix : '0;
    rep.primed      = have_avg;
    rep.fault       = out_of_window;
    rep.rising      = temp_rise;
    rep.falling     = temp_fall;
    owed_reports.push_back(rep);
    if (it.take_up)
      temp_rise = 1'b0;
    if (it.take_down)
      temp_fall = 1'b0;
  endfunction

  // Called for every accepted output transfer.
  function void compare_report(aetm_pkg::out_item_t got);
    aetm_pkg::out_item_t want;
    if (owed_reports.size() == 0) begin
      bad_reports++;
      if (bad_reports <= 10)
        $display("unexpected report: last=%0d filt=%0d primed=%0b fault=%0b rise=%0b fall=%0b",
                 got.last_sample, got.filtered, got.primed, got.fault,
                 got.rising, got.falling);
      return;
    end
    want = owed_reports.pop_front();
    if (got.last_sample !== want.last_sample || got.filtered !== want.filtered ||
        got.primed !== want.primed || got.fault !== want.fault ||
        got.rising !== want.rising || got.falling !== want.falling) begin
      bad_reports++;
      if (bad_reports <= 10) begin
        $display("mismatch expected: last=%0d filt=%0d primed=%0b fault=%0b rise=%0b fall=%0b",
                 want.last_sample, want.filtered, want.primed, want.fault,
                 want.rising, want.falling);
        $display("           actual: last=%0d filt=%0d primed=%0b fault=%0b rise=%0b fall=%0b",
                 got.last_sample, got.filtered, got.primed, got.fault,
                 got.rising, got.falling);
      end
    end
  endfunction
endclass

module adc_ema_trend_monitor_top_test;
  import aetm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 235;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_item_t in_data;
  logic out_valid;
  logic out_stall;
  out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  ema_trend_scoreboard sb;
  bit no_idle;
  bit hold_req;
  int quiet_cycles;

  adc_ema_trend_monitor_top u_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.absorb_item(in_data);
      if (out_valid && !out_stall)
        sb.compare_report(out_data);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: a random stall before each transfer, or one long hold-off on request.
  initial begin
    int n;
    bit held;
    out_stall = 1'b0;
    held = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 16);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic in_item_t mk(bit has, int unsigned s, bit up, bit down);
    in_item_t it;
    it.has_sample = has;
    it.sample     = s[ADC_BITS-1:0];
    it.take_up    = up;
    it.take_down  = down;
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
  endtask

  // The first edge lets the monitor note the last accepted transfer.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0)
      @(posedge clk);
  endtask

  // Back-to-back APB writes: each access phase is followed directly by the next setup.
  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
  endtask

  task automatic apply_config(int unsigned lo, int unsigned hi, int unsigned alpha,
                              int unsigned thr);
    write_reg(REG_RAW_MIN, lo);
    write_reg(REG_RAW_MAX, hi);
    write_reg(REG_ALPHA, alpha);
    write_reg(REG_THRESHOLD, thr);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic int unsigned pick_value(int unsigned top);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return top;
      default: return $urandom_range(0, top);
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int unsigned lo;
    int unsigned hi;
    int unsigned s;
    lo = sb.win_lo;
    hi = sb.win_hi;
    case ($urandom_range(0, 9))
      0: s = $urandom_range(0, 1) ? 4095 : 0;
      1: s = $urandom_range(0, 1) ? lo : lo - 1;
      2: s = $urandom_range(0, 1) ? hi : hi + 1;
      3, 4: s = $urandom_range(0, 4095);
      default: s = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, 4095);
    endcase
    it = mk($urandom_range(0, 7) != 0, s & 12'hfff,
            $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
    return it;
  endfunction

  initial begin
    int unsigned lo;
    int unsigned hi;
    int unsigned tmp;
    int unsigned thr;
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    no_idle = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Default window: read-only items before any sample, faults before priming,
    // priming at the window edge, both trend directions, take bits on set flags,
    // and trend flags cleared as the fault flag toggles.
    send_item(mk(0, 0, 0, 0));
    send_item(mk(0, 4095, 1, 1));
    send_item(mk(1, 99, 0, 0));
    send_item(mk(1, 4001, 0, 0));
    send_item(mk(1, 100, 0, 0));
    send_item(mk(1, 4000, 0, 0));
    send_item(mk(1, 4000, 0, 1));
    send_item(mk(0, 0, 0, 0));
    send_item(mk(1, 100, 1, 0));
    send_item(mk(1, 100, 0, 0));
    send_item(mk(1, 0, 0, 0));
    send_item(mk(1, 4095, 0, 0));
    send_item(mk(1, 2000, 1, 1));
    drain();

    // Full window, no memory in the filter, zero threshold.
    apply_config(0, 4095, 0, 0);
    send_item(mk(1, 0, 0, 0));
    send_item(mk(1, 4095, 1, 1));
    send_item(mk(1, 4095, 0, 0));
    send_item(mk(1, 4094, 0, 0));
    drain();

    // Heaviest filter weight with the largest threshold.
    apply_config(0, 4095, 255, 4095);
    send_item(mk(1, 0, 0, 0));
    send_item(mk(0, 0, 1, 1));
    drain();

    // Empty window: every sample is a fault.
    apply_config(4095, 0, 128, 5);
    send_item(mk(1, 0, 0, 0));
    send_item(mk(1, 4095, 0, 0));
    send_item(mk(1, 2048, 1, 1));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_config(0, 4095, 255, 0);
        1: apply_config($urandom_range(0, 200), $urandom_range(3800, 4095), 0, 4095);
        default: begin
          lo = pick_value(4095);
          hi = pick_value(4095);
          if (lo > hi && $urandom_range(0, 4) != 0) begin
            tmp = lo;
            lo = hi;
            hi = tmp;
          end
          case ($urandom_range(0, 5))
            0: thr = 0;
            1: thr = 4095;
            default: thr = $urandom_range(0, 60);
          endcase
          apply_config(lo, hi, pick_value(255), thr);
        end
      endcase
      no_idle = (p == 3) || (p == 6);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == 60)
          hold_req = 1'b1;
        send_item(random_item());
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (sb.bad_reports == 0 && sb.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
